>>> src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes for the fixed-block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int FIELD_ADDR_W = 32;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_COUNT  = 2'd2,
    CFG_SIZE   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_GET     = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOPOOL   = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_WAIT     = 3'd3,
    ST_BADADDR  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic [FIELD_ADDR_W-1:0] release_address;
    logic                    poll_only;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [FIELD_ADDR_W-1:0] block_address;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EMIT = 2'd1,
    S_FILL = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic cfg_wr;
    logic op_accept;
    logic fill_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic create_go;
    logic get_ok;
    logic fill_last;
  } dp_stat_t;

endpackage

>>> src/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer: handshakes, free-list fill sweep and result hand-off.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fbpa_pkg::dp_cmd_t  cmd,
  input  fbpa_pkg::dp_stat_t stat
);

  import fbpa_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          if (stat.create_go) begin
            state_nxt = S_FILL;
          end
        end else if (in_valid) begin
          cmd.op_accept = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & !out_ready);
  end

  assign out_valid = out_valid_r;

  a_accept_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EMIT))
    else $error("accepted item did not move to result stage");

  a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (!in_ready && !cfg_ready))
    else $error("transfer allowed during free-list fill");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> src/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: config registers, free-list FIFO pointers, range check, results.
// ----------------------------------------------------------------------------
module fbpa_dp #(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbpa_pkg::in_item_t                  in_data,
  input  fbpa_pkg::cfg_idx_t                  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fbpa_pkg::dp_cmd_t                   cmd,
  output fbpa_pkg::dp_stat_t                  stat,
  output fbpa_pkg::out_item_t                 out_data
);

  import fbpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int NW     = (CNT_W > 9) ? CNT_W : 9;
  localparam int SPAN_W = CNT_W + 16;
  localparam int CMP_W  = (ADDR_WIDTH > SPAN_W) ? ADDR_WIDTH : SPAN_W;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == IDX_W'(MAX_BLOCKS - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [31:0]           base_r;
  logic [8:0]            count_r;
  logic [15:0]           size_r;
  logic                  created_r;
  logic [ADDR_WIDTH-1:0] pool_base_r;
  logic [SPAN_W-1:0]     pool_span_r;
  logic [IDX_W-1:0]      head_r;
  logic [IDX_W-1:0]      tail_r;
  logic [CNT_W-1:0]      free_cnt_r;
  logic [IDX_W-1:0]      fill_idx_r;
  logic [CNT_W-1:0]      fill_n_r;
  logic [ADDR_WIDTH-1:0] fill_addr_r;
  status_t               res_status_r;
  logic                  res_get_r;
  out_item_t             out_r;

  logic [NW-1:0]         cnt_ext;
  logic [CNT_W-1:0]      n_new;
  logic [SPAN_W-1:0]     span_new;
  logic [ADDR_WIDTH-1:0] base_masked;
  logic [ADDR_WIDTH-1:0] raddr;
  logic [ADDR_WIDTH-1:0] offset;
  logic                  in_range;
  logic                  full;
  logic                  empty;
  logic                  rel_ok;
  status_t               op_status;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [ADDR_WIDTH-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [ADDR_WIDTH-1:0] ram_rd_data;

  always_comb begin
    cnt_ext     = NW'(count_r);
    n_new       = (cnt_ext > NW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cnt_ext);
    span_new    = SPAN_W'(n_new) * SPAN_W'(size_r);
    base_masked = ADDR_WIDTH'(base_r);
    raddr       = ADDR_WIDTH'(in_data.release_address);
    offset      = raddr - pool_base_r;
    in_range    = (raddr >= pool_base_r) && (CMP_W'(offset) < CMP_W'(pool_span_r));
    full        = (free_cnt_r == CNT_W'(MAX_BLOCKS));
    empty       = (free_cnt_r == '0);

    stat.create_go = (cfg_index == CFG_ENABLE) && cfg_data[0] && !created_r &&
                     (count_r != '0) && (size_r != '0);
    stat.get_ok    = created_r && (in_data.func == FUNC_GET) && !empty;
    stat.fill_last = (CNT_W'(fill_idx_r) == fill_n_r - CNT_W'(1));
    rel_ok         = created_r && (in_data.func == FUNC_RELEASE) && in_range && !full;

    if (!created_r) begin
      op_status = ST_NOPOOL;
    end else if (in_data.func == FUNC_GET) begin
      if (empty) begin
        op_status = in_data.poll_only ? ST_TIMEOUT : ST_WAIT;
      end else begin
        op_status = ST_OK;
      end
    end else if (!in_range) begin
      op_status = ST_BADADDR;
    end else if (full) begin
      op_status = ST_OVERFLOW;
    end else begin
      op_status = ST_OK;
    end
  end

  assign ram_wr_en   = cmd.fill_step | (cmd.op_accept & rel_ok);
  assign ram_wr_addr = cmd.fill_step ? fill_idx_r : tail_r;
  assign ram_wr_data = cmd.fill_step ? fill_addr_r : raddr;
  assign ram_rd_en   = cmd.op_accept & stat.get_ok;

  fbpa_ram #(
    .WIDTH (ADDR_WIDTH),
    .DEPTH (MAX_BLOCKS)
  ) u_free_list (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      count_r    <= 9'd1;
      size_r     <= 16'd1;
      created_r  <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      free_cnt_r <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        case (cfg_index)
          CFG_ENABLE: begin
            if (!cfg_data[0] && created_r) begin
              created_r  <= 1'b0;
              head_r     <= '0;
              tail_r     <= '0;
              free_cnt_r <= '0;
            end
          end
          CFG_BASE:  base_r  <= cfg_data;
          CFG_COUNT: count_r <= cfg_data[8:0];
          CFG_SIZE:  size_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.fill_step && stat.fill_last) begin
        created_r  <= 1'b1;
        head_r     <= '0;
        tail_r     <= (fill_n_r == CNT_W'(MAX_BLOCKS)) ? '0 : IDX_W'(fill_n_r);
        free_cnt_r <= fill_n_r;
      end
      if (cmd.op_accept && stat.get_ok) begin
        head_r     <= next_slot(head_r);
        free_cnt_r <= free_cnt_r - 1'b1;
      end
      if (cmd.op_accept && rel_ok) begin
        tail_r     <= next_slot(tail_r);
        free_cnt_r <= free_cnt_r + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cfg_wr && stat.create_go) begin
      pool_base_r <= base_masked;
      pool_span_r <= span_new;
      fill_idx_r  <= '0;
      fill_addr_r <= base_masked;
      fill_n_r    <= n_new;
    end
    if (cmd.fill_step) begin
      fill_idx_r  <= next_slot(fill_idx_r);
      fill_addr_r <= fill_addr_r + ADDR_WIDTH'(size_r);
    end
    if (cmd.op_accept) begin
      res_status_r <= op_status;
      res_get_r    <= stat.get_ok;
    end
    if (cmd.out_load) begin
      out_r.status        <= res_status_r;
      out_r.block_address <= res_get_r ? FIELD_ADDR_W'(ram_rd_data) : '0;
    end
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(MAX_BLOCKS))
    else $error("free count above list depth");

  a_get_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op_accept && stat.get_ok) |=> (free_cnt_r == $past(free_cnt_r) - 1'b1))
    else $error("successful get did not pop the free list");

endmodule

>>> src/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-block memory pool with a FIFO free list of block addresses.
// ----------------------------------------------------------------------------
// Channels: in_* carries one get or release request, out_* one status and
// block address per request, cfg_* writes the four pool registers.
// All three use valid/ready; a transfer happens when both are high.
// Writing pool_enable = 1 (pool not yet created, count and size nonzero)
// starts a fill sweep that writes one free-list entry per cycle, for
// min(block_count, MAX_BLOCKS) entries; in_ready and cfg_ready stay low then.
// A request's accept cycle does the range check and the free-list push or
// read; the S_EMIT state then loads the output register once it is free,
// and no new request is taken before that load. The free-list RAM read port is the
// stage boundary. A new request is accepted while a result still waits in
// the output register; if the receiver keeps stalling, the second result
// waits inside and no further request is taken until the output frees.
// Reset (synchronous, rst_n low) deletes the pool and restores the register
// defaults: base 0, count 1, size 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbpa_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbpa_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  fbpa_pkg::cfg_idx_t              cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fbpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

>>> tb/fixed_block_pool_allocator_test.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Self-checking bench for the fixed-block pool allocator. A clocked driver
// feeds get and release requests from a queue and a clocked monitor checks
// every returned status and block address against an in-bench model of the
// free list. Directed cases cover the edge cases; randomized phases then
// reprogram the pool and mix well-formed requests with stray addresses.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int POOL_DEPTH    = 256;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  fixed_block_pool_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pool model state
  logic [31:0] free_addrs [POOL_DEPTH];
  logic [7:0]  free_head;
  logic [7:0]  free_tail;
  logic [8:0]  free_total;
  logic        pool_live;
  logic [31:0] pool_base;
  logic [24:0] pool_span;
  logic        reg_enable;
  logic [31:0] reg_base;
  logic [8:0]  reg_count;
  logic [15:0] reg_size;

  in_item_t  request_q[$];
  out_item_t predicted_outcomes[$];
  int        items_issued = 0;
  int        results_seen = 0;
  int        error_count  = 0;
  int        cycle_count  = 0;
  bit        steady       = 1'b0;

  // Stimulus view of the pool being programmed
  logic [31:0] cur_base;
  logic [15:0] cur_size;
  int          cur_blocks;

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void pool_clear();
    for (int i = 0; i < POOL_DEPTH; i++) free_addrs[i] = '0;
    free_head  = '0;
    free_tail  = '0;
    free_total = '0;
    pool_live  = 1'b0;
    pool_base  = '0;
    pool_span  = '0;
  endfunction

  function automatic void pool_create();
    logic [8:0]  n;
    logic [31:0] addr;
    if (reg_count == 0 || reg_size == 0) return;
    n = (reg_count > POOL_DEPTH) ? 9'(POOL_DEPTH) : reg_count;
    pool_clear();
    pool_base = reg_base;
    pool_span = n * reg_size;
    addr = reg_base;
    for (int i = 0; i < n; i++) begin
      free_addrs[i] = addr;
      addr = addr + reg_size;
    end
    free_tail  = n[7:0];
    free_total = n;
    pool_live  = 1'b1;
  endfunction

  function automatic void pool_reset_model();
    pool_clear();
    reg_enable = 1'b0;
    reg_base   = '0;
    reg_count  = 9'd1;
    reg_size   = 16'd1;
  endfunction

  function automatic void apply_pool_reg(cfg_idx_t idx, logic [31:0] val);
    case (idx)
      CFG_ENABLE: begin
        reg_enable = val[0];
        if (reg_enable) begin
          if (!pool_live) pool_create();
        end else if (pool_live) begin
          pool_clear();
        end
      end
      CFG_BASE:  reg_base  = val;
      CFG_COUNT: reg_count = val[8:0];
      CFG_SIZE:  reg_size  = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_outcome(in_item_t req);
    out_item_t   res;
    logic [31:0] offset;
    res.status        = ST_OK;
    res.block_address = '0;
    offset = req.release_address - pool_base;
    if (!pool_live) begin
      res.status = ST_NOPOOL;
    end else if (req.func == FUNC_GET) begin
      if (free_total == 0) begin
        res.status = req.poll_only ? ST_TIMEOUT : ST_WAIT;
      end else begin
        res.block_address = free_addrs[free_head];
        free_head++;
        free_total--;
      end
    end else if (req.release_address < pool_base || offset >= pool_span) begin
      res.status = ST_BADADDR;
    end else if (free_total >= POOL_DEPTH) begin
      res.status = ST_OVERFLOW;
    end else begin
      free_addrs[free_tail] = req.release_address;
      free_tail++;
      free_total++;
    end
    return res;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_outcomes.push_back(predict_outcome(in_data));
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d addr %h",
                                    out_data.status, out_data.block_address));
        end else begin
          want = predicted_outcomes.pop_front();
          results_seen++;
          if (out_data.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_seen, out_data.status, want.status));
          if (out_data.block_address !== want.block_address)
            report_mismatch($sformatf("result %0d addr %h, want %h", results_seen,
                                      out_data.block_address, want.block_address));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_get(logic poll);
    in_item_t r;
    r.func            = FUNC_GET;
    r.release_address = $urandom();
    r.poll_only       = poll;
    request_q.push_back(r);
    items_issued++;
  endtask

  task automatic queue_release(logic [31:0] addr);
    in_item_t r;
    r.func            = FUNC_RELEASE;
    r.release_address = addr;
    r.poll_only       = 1'($urandom_range(1));
    request_q.push_back(r);
    items_issued++;
  endtask

  function automatic logic [31:0] stray_address();
    logic [31:0] span;
    span = 32'(cur_blocks) * cur_size;
    case ($urandom_range(3))
      0: return $urandom();
      1: return cur_base - 1;
      2: return cur_base + span;
      default: return cur_base + span - 1;
    endcase
  endfunction

  // Returns at a rising edge once every result is in and the block has settled
  task automatic wait_idle();
    @(posedge clk);
    while (results_seen != items_issued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge; leaves cfg_valid high for a following write
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_pool_reg(idx, val);
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
    repeat (1 + $urandom_range(2)) @(posedge clk);
  endtask

  task automatic setup_pool(logic [31:0] base, logic [8:0] count, logic [15:0] bsize);
    write_reg(CFG_BASE, base);
    write_reg(CFG_COUNT, 32'(count));
    write_reg(CFG_SIZE, 32'(bsize));
    write_reg(CFG_ENABLE, 32'd1);
    end_cfg();
    cur_base   = base;
    cur_size   = bsize;
    cur_blocks = (count == 0) ? 1 : (count > POOL_DEPTH) ? POOL_DEPTH : int'(count);
  endtask

  task automatic teardown();
    write_reg(CFG_ENABLE, 32'd0);
    end_cfg();
  endtask

  initial begin : stimulus
    int          n_random;
    int          phase;
    int          batch;
    int          get_pct;
    logic [31:0] base;
    logic [8:0]  count;
    logic [15:0] bsize;
    n_random = 0;
    phase    = 0;
    pool_reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // no pool yet
    queue_get(1'b0);
    queue_release(32'h0);
    wait_idle();
    teardown();

    // zero count, then zero size: pool stays down
    setup_pool(32'h0000_1000, 9'd0, 16'd4);
    queue_get(1'b1);
    wait_idle();
    teardown();
    setup_pool(32'h0000_1000, 9'd2, 16'd0);
    queue_release(32'h0000_1000);
    wait_idle();
    teardown();

    // pool wrapping past the top of the address space
    setup_pool(32'hFFFF_FFF0, 9'd3, 16'd16);
    queue_get(1'b0);
    queue_get(1'b1);
    queue_get(1'b0);
    queue_get(1'b1);
    queue_get(1'b0);
    queue_release(32'hFFFF_FFF0);
    queue_release(32'h0000_0000);
    queue_release(32'hFFFF_FFFF);
    queue_release(32'hFFFF_FFEF);
    queue_get(1'b0);
    queue_get(1'b1);
    wait_idle();

    // re-enable and base change while live are ignored
    write_reg(CFG_BASE, 32'h0);
    write_reg(CFG_ENABLE, 32'd1);
    end_cfg();
    queue_release(32'hFFFF_FFF5);
    queue_get(1'b0);
    wait_idle();
    teardown();

    // oversized count saturates; full list overflows
    setup_pool(32'h0, 9'd511, 16'hFFFF);
    queue_release(32'h0);
    queue_release(32'h00FF_FF00);
    queue_get(1'b0);
    queue_release(32'h00FF_FEFF);
    queue_release(32'h0);
    wait_idle();
    teardown();

    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hFFFF_FFFF - $urandom_range(65535);
        default: base = $urandom();
      endcase
      case ($urandom_range(19))
        0:       count = 9'd0;
        1, 2:    count = 9'd256;
        3:       count = 9'($urandom_range(257, 511));
        4:       count = 9'($urandom_range(17, 255));
        default: count = 9'($urandom_range(1, 16));
      endcase
      case ($urandom_range(19))
        0:       bsize = 16'd0;
        1, 2:    bsize = 16'd1;
        3, 4:    bsize = 16'hFFFF;
        5, 6, 7: bsize = 16'($urandom_range(1, 64));
        default: bsize = 16'($urandom_range(1, 65535));
      endcase
      setup_pool(base, count, bsize);
      steady  = (phase == 4);
      batch   = steady ? 200 : $urandom_range(20, 120);
      get_pct = 30 + 20 * $urandom_range(2);
      for (int k = 0; k < batch; k++) begin
        if ($urandom_range(99) < get_pct)
          queue_get(1'($urandom_range(1)));
        else if ($urandom_range(99) < 85)
          queue_release(cur_base + 32'($urandom_range(cur_blocks - 1)) * cur_size);
        else
          queue_release(stray_address());
      end
      n_random += batch;
      wait_idle();
      steady = 1'b0;
      if ($urandom_range(5) != 0) teardown();
      phase++;
    end

    wait_idle();
    if (predicted_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_outcomes.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
